FILE: src/plrt_pkg.sv
// Package for the piecewise-linear RGBA transfer block.
// Holds point and pipeline payload types, register indexes and sizing constants.
// No dependencies.
package plrt_pkg;

    localparam int CHAN_W             = 8;
    localparam int NUM_CHAN           = 4;
    localparam int POINT_W            = CHAN_W * (NUM_CHAN + 1);
    localparam int COUNT_W            = 3;
    localparam int REG_POINTS         = 7;
    localparam int MAX_POINTS_DEFAULT = 7;
    localparam int INDEX_W            = 3;
    localparam int NUM_W              = 2 * CHAN_W;
    localparam int QUO_BITS           = CHAN_W;

    localparam logic [INDEX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [INDEX_W-1:0] REG_POINT_FIRST = 3'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;   // red in chan[0] ... alpha in chan[3]
        chan_t                           level;
    } point_t;

    typedef struct packed {
        chan_t  sample;
        logic   found;
        point_t lo;
        point_t hi;
    } seg_t;

    typedef struct packed {
        chan_t                           divisor;
        logic [NUM_CHAN-1:0][NUM_W-1:0]  rem;
        logic [NUM_CHAN-1:0][CHAN_W-1:0] quo;
    } div_t;

endpackage

FILE: src/piecewise_linear_rgba_transfer_top.sv
// Top level of the piecewise-linear RGBA transfer block.
// Instantiates plrt_seg_cell, plrt_mul_stage and plrt_div_cell; uses plrt_pkg.
//
// Maps each 8-bit sample to RGBA by interpolating between up to MAX_POINTS
// control points written through the cfg port. The block is a row of cells:
// an entry register, MAX_POINTS-1 segment cells, one weighting stage and eight
// restoring-division cells, one per quotient bit. Each cell hands its
// transaction to the next when that one is free, so a new sample is taken
// every cycle while the output is not stalled. A sample passes in order
// through the entry register, the MAX_POINTS-1 segment cells, the weighting
// stage and the eight division cells. The last division cell is the output
// register; a stalled output holds the chain back cell by cell.
// Write cfg only while no sample is in flight.
module piecewise_linear_rgba_transfer_top
    import plrt_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,    // red, green, blue, alpha
    input  logic                 cfg_we,
    input  logic [INDEX_W-1:0]   cfg_index,
    input  logic [POINT_W-1:0]   cfg_data
);

    localparam int NUM_SEG = MAX_POINTS - 1;

    count_t count_reg;
    point_t points_reg [REG_POINTS];
    count_t n_eff;
    point_t fallback;

    logic   entry_valid_reg;
    seg_t   entry_reg;
    seg_t   entry_next;
    logic   entry_ready;

    logic   seg_valid [NUM_SEG+1];
    logic   seg_ready [NUM_SEG+1];
    seg_t   seg_data  [NUM_SEG+1];

    logic   div_valid [QUO_BITS+1];
    logic   div_ready [QUO_BITS+1];
    div_t   div_data  [QUO_BITS+1];

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            for (int k = 0; k < REG_POINTS; k++)
            begin
                points_reg[k] <= '0;
            end
            points_reg[1] <= '1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POINT_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            else
            begin
                points_reg[cfg_index - REG_POINT_FIRST] <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(MAX_POINTS))
        begin
            n_eff = COUNT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    // seed the chain with the colour used when no segment encloses the sample
    assign fallback = (s_tdata < points_reg[0].level) ? points_reg[0]
                                                      : points_reg[n_eff - COUNT_W'(1)];

    always_comb
    begin
        entry_next        = '0;
        entry_next.sample = s_tdata;
        entry_next.found  = 1'b0;
        entry_next.lo     = fallback;
        entry_next.hi     = fallback;
    end

    assign s_tready = !entry_valid_reg || entry_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            entry_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            entry_reg <= entry_next;
        end
    end

    assign seg_valid[0] = entry_valid_reg;
    assign seg_data[0]  = entry_reg;
    assign entry_ready  = seg_ready[0];

    for (genvar k = 0; k < NUM_SEG; k++)
    begin : g_seg
        plrt_seg_cell #(
            .INDEX (k)
        ) u_seg_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .n_eff     (n_eff),
            .lo_pt     (points_reg[k]),
            .hi_pt     (points_reg[k+1]),
            .in_valid  (seg_valid[k]),
            .in_ready  (seg_ready[k]),
            .in_data   (seg_data[k]),
            .out_valid (seg_valid[k+1]),
            .out_ready (seg_ready[k+1]),
            .out_data  (seg_data[k+1])
        );
    end

    plrt_mul_stage u_mul_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid[NUM_SEG]),
        .in_ready  (seg_ready[NUM_SEG]),
        .in_data   (seg_data[NUM_SEG]),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        plrt_div_cell #(
            .BIT (QUO_BITS - 1 - j)
        ) u_div_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[j]),
            .in_ready  (div_ready[j]),
            .in_data   (div_data[j]),
            .out_valid (div_valid[j+1]),
            .out_ready (div_ready[j+1]),
            .out_data  (div_data[j+1])
        );
    end

    assign m_tvalid             = div_valid[QUO_BITS];
    assign div_ready[QUO_BITS]  = m_tready;
    assign m_tdata              = div_data[QUO_BITS].quo;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_eff >= COUNT_W'(1)) && (n_eff <= COUNT_W'(MAX_POINTS)))
        else $error("effective point count out of range");

    a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (entry_valid_reg && entry_reg.sample == $past(s_tdata)
                                    && !entry_reg.found))
        else $error("accepted sample not held in the entry register");

endmodule

FILE: src/plrt_seg_cell.sv
// One segment cell of the search chain: checks one segment against the sample.
// Latches the segment's end points on the first enclosing match. Uses plrt_pkg.
module plrt_seg_cell
    import plrt_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  count_t n_eff,
    input  point_t lo_pt,
    input  point_t hi_pt,
    input  logic   in_valid,
    output logic   in_ready,
    input  seg_t   in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output seg_t   out_data
);

    logic valid_reg;
    seg_t data_reg;
    seg_t data_next;
    logic hit;

    assign hit = !in_data.found
                 && (n_eff > COUNT_W'(INDEX + 1))
                 && (lo_pt.level <= in_data.sample)
                 && (in_data.sample <= hi_pt.level);

    always_comb
    begin
        data_next = in_data;
        if (hit)
        begin
            data_next.found = 1'b1;
            data_next.lo    = lo_pt;
            data_next.hi    = hi_pt;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    a_found_encloses: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.found) |->
            (data_reg.lo.level <= data_reg.sample && data_reg.sample <= data_reg.hi.level))
        else $error("segment cell holds a segment that does not enclose its sample");

endmodule

FILE: src/plrt_mul_stage.sv
// Weighting stage: forms the numerator a*(span-t)+b*t and the divisor per channel.
// Flat cases (no enclosing segment, zero-width segment) pass the lower colour over 1.
// Uses plrt_pkg.
module plrt_mul_stage
    import plrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  seg_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;
    chan_t span;
    chan_t offset;
    chan_t rest;
    logic  flat;
    logic [NUM_CHAN-1:0][NUM_W-1:0] prod_lo;
    logic [NUM_CHAN-1:0][NUM_W-1:0] prod_hi;

    assign span   = in_data.hi.level - in_data.lo.level;
    assign offset = in_data.sample - in_data.lo.level;
    assign rest   = span - offset;
    assign flat   = !in_data.found || (span == '0);

    always_comb
    begin
        data_next         = '0;
        data_next.divisor = flat ? CHAN_W'(1) : span;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            prod_lo[c] = NUM_W'(in_data.lo.chan[c]) * NUM_W'(rest);
            prod_hi[c] = NUM_W'(in_data.hi.chan[c]) * NUM_W'(offset);
            data_next.rem[c] = flat ? NUM_W'(in_data.lo.chan[c]) : (prod_lo[c] + prod_hi[c]);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: src/plrt_div_cell.sv
// One restoring-division cell: settles quotient bit BIT for all four channels.
// Chained from the top bit down; uses plrt_pkg.
module plrt_div_cell
    import plrt_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [NUM_W-1:0] dsh;
    logic [NUM_W-1:0] out_dsh;

    assign dsh     = NUM_W'(in_data.divisor) << BIT;
    assign out_dsh = NUM_W'(data_reg.divisor) << BIT;

    always_comb
    begin
        data_next = in_data;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (in_data.rem[c] >= dsh)
            begin
                data_next.rem[c]      = in_data.rem[c] - dsh;
                data_next.quo[c][BIT] = 1'b1;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.divisor != '0))
        else $error("division cell holds a zero divisor");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((data_reg.rem[0] < out_dsh) && (data_reg.rem[1] < out_dsh)
                       && (data_reg.rem[2] < out_dsh) && (data_reg.rem[3] < out_dsh)))
        else $error("division cell remainder exceeds its shifted divisor");

endmodule

FILE: bench/tb.sv
// Testbench for piecewise_linear_rgba_transfer_top: directed table, then random control points.
// Predicts each RGBA colour in-bench and checks every output transaction in order.
// Depends on plrt_pkg and the RTL top level only.
module tb;
    import plrt_pkg::*;

    localparam int LATENCY    = MAX_POINTS_DEFAULT + 10;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 140;
    localparam int N_STEPS    = 38;

    typedef struct packed {
        bit                 is_write;
        logic [INDEX_W-1:0] idx;
        logic [POINT_W-1:0] val;
        logic [7:0]         smp;
        bit                 known;
        logic [31:0]        rgba;
    } step_t;

    localparam step_t STEPS [N_STEPS] = '{
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h00, 1'b1, 32'h00000000},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'hff, 1'b1, 32'hffffffff},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h80, 1'b1, 32'h80808080},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h01, 1'b1, 32'h01010101},
        '{1'b1, REG_POINT_COUNT, 40'd1, 8'h00, 1'b0, 32'h0},
        '{1'b1, REG_POINT_FIRST, 40'h44_33_22_11_40, 8'h00, 1'b0, 32'h0},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h00, 1'b1, 32'h44332211},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h40, 1'b1, 32'h44332211},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'hff, 1'b1, 32'h44332211},
        '{1'b1, REG_POINT_COUNT, 40'd0, 8'h00, 1'b0, 32'h0},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h80, 1'b1, 32'h44332211},
        '{1'b1, REG_POINT_COUNT, 40'd3, 8'h00, 1'b0, 32'h0},
        '{1'b1, REG_POINT_FIRST, 40'hff_00_80_20_10, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 1), 40'h00_ff_40_aa_10, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 2), 40'h80_c0_ff_00_f0, 8'h00, 1'b0, 32'h0},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h10, 1'b1, 32'hff008020},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h05, 1'b1, 32'hff008020},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'hff, 1'b1, 32'h80c0ff00},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'hf0, 1'b1, 32'h80c0ff00},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h80, 1'b0, 32'h0},
        '{1'b1, REG_POINT_COUNT, 40'd4, 8'h00, 1'b0, 32'h0},
        '{1'b1, REG_POINT_FIRST, 40'h10_20_30_40_20, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 1), 40'h50_60_70_80_40, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 2), 40'h90_a0_b0_c0_10, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 3), 40'hd0_e0_f0_ff_30, 8'h00, 1'b0, 32'h0},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h45, 1'b1, 32'hd0e0f0ff},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h05, 1'b1, 32'h10203040},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h18, 1'b0, 32'h0},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h30, 1'b0, 32'h0},
        '{1'b1, REG_POINT_COUNT, 40'd7, 8'h00, 1'b0, 32'h0},
        '{1'b1, REG_POINT_FIRST, 40'h00_00_00_00_00, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 1), 40'hff_ff_ff_ff_ff, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 4), 40'h01_02_03_04_ff, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 5), 40'hff_ff_ff_ff_ff, 8'h00, 1'b0, 32'h0},
        '{1'b1, 3'(REG_POINT_FIRST + 6), 40'h00_00_00_00_00, 8'h00, 1'b0, 32'h0},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h7f, 1'b0, 32'h0},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'h00, 1'b0, 32'h0},
        '{1'b0, REG_POINT_COUNT, 40'h0, 8'hff, 1'b0, 32'h0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_we = 1'b0;
    logic [INDEX_W-1:0]   cfg_index = '0;
    logic [POINT_W-1:0]   cfg_data = '0;

    count_t      active_count;
    point_t      ctrl_pts [REG_POINTS];
    logic [31:0] rgba_q [$];
    logic [31:0] want_rgba;
    string       chan_name [NUM_CHAN] = '{"red", "green", "blue", "alpha"};
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_settings = 0;
    int          hold_cnt = 0;
    bit          tx_gaps = 1'b0;
    bit          rx_stalls = 1'b0;

    piecewise_linear_rgba_transfer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("[piecewise_linear_rgba_transfer_top] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] map_sample(input logic [7:0] smp);
        int     n;
        int     span;
        int     t;
        point_t lo;
        point_t hi;
        logic [31:0] rgba;
        n = (active_count == 0) ? 1 : int'(active_count);
        if (n > MAX_POINTS_DEFAULT)
            n = MAX_POINTS_DEFAULT;
        for (int k = 0; k + 1 < n; k++)
        begin
            lo = ctrl_pts[k];
            hi = ctrl_pts[k + 1];
            if (lo.level <= smp && smp <= hi.level)
            begin
                span = int'(hi.level) - int'(lo.level);
                if (span == 0)
                    return lo.chan;
                t = int'(smp) - int'(lo.level);
                for (int c = 0; c < NUM_CHAN; c++)
                    rgba[c*CHAN_W +: CHAN_W] =
                        8'((int'(lo.chan[c]) * (span - t) + int'(hi.chan[c]) * t) / span);
                return rgba;
            end
        end
        if (smp < ctrl_pts[0].level)
            return ctrl_pts[0].chan;
        return ctrl_pts[n - 1].chan;
    endfunction

    task automatic send_sample(input logic [7:0] smp, input bit known,
                               input logic [31:0] rgba);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge clk); while (!s_tready);
        rgba_q.push_back(known ? rgba : map_sample(smp));
        n_sent++;
    endtask

    // hold the sender until every colour in flight has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (rgba_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [POINT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_POINT_COUNT)
            active_count = val[COUNT_W-1:0];
        else
            ctrl_pts[idx - REG_POINT_FIRST] = point_t'(val);
    endtask

    task automatic random_setting(input int style);
        int          lvq [$];
        int          cnt;
        int          r;
        logic [31:0] colour;
        logic [POINT_W-1:0] pv;
        r = $urandom_range(0, 5);
        if (style < 2)
            cnt = 7;
        else
            cnt = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 7 : $urandom_range(2, 7);
        for (int k = 0; k < REG_POINTS; k++)
            lvq.push_back($urandom_range(0, 255));
        if (style == 2 || style == 3)
        begin
            lvq.sort();
            if ($urandom_range(0, 1) == 1)
            begin
                lvq[0] = 0;
                lvq[REG_POINTS-1] = 255;
            end
        end
        if (style == 3)
            for (int k = 1; k < REG_POINTS; k++)
                if ($urandom_range(0, 2) == 0)
                    lvq[k] = lvq[k - 1];
        write_reg(REG_POINT_COUNT, POINT_W'(cnt));
        for (int k = 0; k < REG_POINTS; k++)
        begin
            r = $urandom_range(0, 7);
            colour = (r == 0) ? 32'h0 : (r == 1) ? 32'hffffffff : $urandom;
            if (style == 0)
                pv = '1;
            else if (style == 1)
                pv = '0;
            else
                pv = {colour, 8'(lvq[k])};
            write_reg(3'(REG_POINT_FIRST + k), pv);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [7:0] random_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
        if (r == 1)
            return 8'(int'(ctrl_pts[$urandom_range(0, REG_POINTS-1)].level)
                      + $urandom_range(0, 2) - 1);
        return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cnt != 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else if (rx_stalls && $urandom_range(0, 3) == 0)
        begin
            hold_cnt = pick_gap() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rgba_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: colour %h with none expected", $time, m_tdata);
            end
            else
            begin
                want_rgba = rgba_q.pop_front();
                for (int c = 0; c < NUM_CHAN; c++)
                    if (m_tdata[c*CHAN_W +: CHAN_W] !== want_rgba[c*CHAN_W +: CHAN_W])
                    begin
                        n_errors++;
                        $display("%0t: %s expected %h actual %h", $time, chan_name[c],
                                 want_rgba[c*CHAN_W +: CHAN_W], m_tdata[c*CHAN_W +: CHAN_W]);
                    end
                n_checked++;
            end
        end
    end

    initial
    begin
        bit writing;
        int style;
        writing = 1'b0;
        active_count = COUNT_RESET;
        for (int k = 0; k < REG_POINTS; k++)
            ctrl_pts[k] = '0;
        ctrl_pts[1] = '1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_STEPS; i++)
        begin
            if (STEPS[i].is_write)
            begin
                if (!writing)
                begin
                    drain();
                    writing = 1'b1;
                end
                write_reg(STEPS[i].idx, STEPS[i].val);
            end
            else
            begin
                if (writing)
                begin
                    cfg_we <= 1'b0;
                    writing = 1'b0;
                end
                send_sample(STEPS[i].smp, STEPS[i].known, STEPS[i].rgba);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            style = (p < 2) ? p : ($urandom_range(0, 2) == 0) ? 4 : $urandom_range(2, 3);
            random_setting(style);
            tx_gaps   = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_stalls = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int j = 0; j < PHASE_LEN; j++)
            begin
                if (j == PHASE_LEN / 2 && (p == 3 || $urandom_range(0, 2) == 0))
                    drain();
                send_sample(random_sample(), 1'b0, 32'h0);
            end
        end

        drain();
        repeat (LATENCY + 8) @(posedge clk);
        if (rgba_q.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d colours never arrived", $time, rgba_q.size());
        end
        $display("Mapped %0d samples over %0d random point settings; %0d colours checked.",
                 n_sent, n_settings, n_checked);
        if (n_errors == 0)
            $display("[piecewise_linear_rgba_transfer_top] OK");
        else
            $display("[piecewise_linear_rgba_transfer_top] ERROR");
        $finish;
    end

endmodule
